### rtl/tei_pkg.sv
// shared types and constants for the terminal escape input decoder
package tei_pkg;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       more_waiting;
   } req_type;

   typedef struct packed {
      logic [2:0]  event_kind;
      logic [3:0]  key_code;
      logic [7:0]  char_value;
      logic [2:0]  mouse_button;
      logic        mouse_released;
      logic signed [15:0] mouse_x;
      logic signed [15:0] mouse_y;
      logic [6:0]  pressed_map;
      logic [6:0]  released_map;
      logic        last_of_run;
   } rsp_type;

   localparam logic [2:0] KIND_KEY        = 3'd0;
   localparam logic [2:0] KIND_CHAR       = 3'd1;
   localparam logic [2:0] KIND_MOUSE      = 3'd2;
   localparam logic [2:0] KIND_PASTE      = 3'd3;
   localparam logic [2:0] KIND_PASTE_END  = 3'd4;

   localparam logic [3:0] KEY_ESCAPE    = 4'd0;
   localparam logic [3:0] KEY_SPACE     = 4'd1;
   localparam logic [3:0] KEY_ENTER     = 4'd2;
   localparam logic [3:0] KEY_TAB       = 4'd3;
   localparam logic [3:0] KEY_BACKSPACE = 4'd4;
   localparam logic [3:0] KEY_DELETE    = 4'd5;
   localparam logic [3:0] KEY_INSERT    = 4'd6;
   localparam logic [3:0] KEY_UP        = 4'd7;
   localparam logic [3:0] KEY_DOWN      = 4'd8;
   localparam logic [3:0] KEY_LEFT      = 4'd9;
   localparam logic [3:0] KEY_RIGHT     = 4'd10;

   localparam logic [7:0] CH_ESC = 8'h1B;
   localparam logic [7:0] CH_DEL = 8'h7F;

endpackage

### rtl/terminal_escape_input_decoder.sv
// top level of the terminal escape input decoder
// Usage: one terminal byte per req_ transfer (req_data.in_byte plus
// req_data.more_waiting). Each byte yields zero, one or two result items on
// the rsp_ channel; last_of_run marks the final one of a byte.
// A result enters the output register when the decoder fires on its byte
// in the input register. Throughput: one byte per cycle while results are
// taken at once; a byte that makes two results holds off the next byte
// until its second result leaves the one-entry holding register, since the
// output register sends one item per cycle.
// Bytes flow through an input register; the decoder runs between the input
// register and the output register in a single pass.
// Reset: parser in normal mode, all button state cleared, no items pending.
// Stall: when rsp_ready is low the output register holds its item; the
// input register still takes one more byte, then req_ready drops until
// the result side drains.
// Paste content appears five bytes after it arrives; the terminator
// ESC[201~ is not emitted.
module terminal_escape_input_decoder #(
   parameter int COORD_MAX = 32767
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tei_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tei_pkg::rsp_type rsp_data
);

   localparam logic [2:0] M_NORMAL = 3'd0;
   localparam logic [2:0] M_ESC    = 3'd1;
   localparam logic [2:0] M_CSI    = 3'd2;
   localparam logic [2:0] M_MOUSE  = 3'd3;
   localparam logic [2:0] M_PASTE  = 3'd4;
   // accumulator holds any value up to COORD_MAX and at least the 16 result bits
   localparam int AW = ($clog2(COORD_MAX) + 5 > 16) ? $clog2(COORD_MAX) + 5 : 16;

   // input register
   logic             in_vld_ff;
   tei_pkg::req_type in_ff;
   // output register and second-result holding register
   logic             out_vld_ff, hold_vld_ff;
   tei_pkg::rsp_type out_ff, hold_ff;

   // parser state
   logic [2:0]  mode_ff;
   logic [7:0]  csi_ff [4];
   logic [2:0]  csi_len_ff;
   logic [1:0]  sect_ff;
   logic [7:0]  btxt_ff [2];
   logic [1:0]  blen_ff;
   logic [AW-1:0] acc_ff [2];
   logic [3:0]  flg_ff [2];
   logic [7:0]  win_ff [6];
   logic [2:0]  fill_ff;
   logic [6:0]  pmap_ff, rmap_ff;

   logic [2:0]  mode_in;
   logic [7:0]  csi_in [4];
   logic [2:0]  csi_len_in;
   logic [1:0]  sect_in;
   logic [7:0]  btxt_in [2];
   logic [1:0]  blen_in;
   logic [AW-1:0] acc_in [2];
   logic [3:0]  flg_in [2];
   logic [7:0]  win_in [6];
   logic [2:0]  fill_in;
   logic [6:0]  pmap_in, rmap_in;

   logic             r0_v, r1_v;
   tei_pkg::rsp_type r0, r1;

   // decoder fires when a byte waits in the input register and the output register and holding register are free
   logic out_free, fire;
   assign out_free  = !hold_vld_ff && (!out_vld_ff || rsp_ready);
   assign fire      = in_vld_ff && out_free;
   assign req_ready = !in_vld_ff || fire;
   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   function automatic tei_pkg::rsp_type mk(input logic [2:0] kind, input logic [3:0] key,
                                           input logic [7:0] ch);
      tei_pkg::rsp_type r;
      r = '0;
      r.event_kind = kind;
      r.key_code = key;
      r.char_value = ch;
      return r;
   endfunction

   // plain key decode: valid flag plus item
   function automatic logic plain_ok(input logic [7:0] b);
      return (b inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39], 8'h20, 8'h0A, 8'h0D,
                        8'h09, 8'h08, tei_pkg::CH_DEL, tei_pkg::CH_ESC});
   endfunction

   function automatic tei_pkg::rsp_type plain_item(input logic [7:0] b);
      tei_pkg::rsp_type r;
      case (b)
         8'h20:           r = mk(tei_pkg::KIND_KEY, tei_pkg::KEY_SPACE, 8'h00);
         8'h0A, 8'h0D:    r = mk(tei_pkg::KIND_KEY, tei_pkg::KEY_ENTER, 8'h00);
         8'h09:           r = mk(tei_pkg::KIND_KEY, tei_pkg::KEY_TAB, 8'h00);
         8'h08:           r = mk(tei_pkg::KIND_KEY, tei_pkg::KEY_BACKSPACE, 8'h00);
         tei_pkg::CH_DEL: r = mk(tei_pkg::KIND_KEY, tei_pkg::KEY_DELETE, 8'h00);
         tei_pkg::CH_ESC: r = mk(tei_pkg::KIND_KEY, tei_pkg::KEY_ESCAPE, 8'h00);
         default:         r = mk(tei_pkg::KIND_CHAR, 4'd0, b);
      endcase
      return r;
   endfunction

   logic [7:0] b;
   logic       more;
   logic       is_digit;
   logic [AW+3:0] acc10 [2];
   logic [2:0] bcode;
   logic       bcode_ok;
   logic [6:0] bbit;
   logic       rel;
   logic       mouse_ok;
   logic signed [16:0] cval [2];

   always_comb begin
      b = in_ff.in_byte;
      more = in_ff.more_waiting;
      is_digit = (b inside {[8'h30:8'h39]});
      mode_in = mode_ff;
      csi_in = csi_ff;
      csi_len_in = csi_len_ff;
      sect_in = sect_ff;
      btxt_in = btxt_ff;
      blen_in = blen_ff;
      acc_in = acc_ff;
      flg_in = flg_ff;
      win_in = win_ff;
      fill_in = fill_ff;
      pmap_in = pmap_ff;
      rmap_in = rmap_ff;
      r0_v = 1'b0;
      r1_v = 1'b0;
      r0 = '0;
      r1 = '0;
      bcode = 3'd0;
      bcode_ok = 1'b0;
      bbit = '0;
      rel = (b == 8'h6D);
      mouse_ok = 1'b0;
      for (int k = 0; k < 2; k++) begin
         acc10[k] = {4'd0, acc_ff[k]} * (AW + 4)'(10) + (AW + 4)'(b - 8'h30);
         cval[k] = flg_ff[k][0] ? -$signed({1'b0, acc_ff[k][15:0]}) - 17'sd1
                                : $signed({1'b0, acc_ff[k][15:0]}) - 17'sd1;
      end
      // button text
      if (blen_ff == 2'd1) begin
         bcode_ok = (btxt_ff[0] inside {8'h30, 8'h31, 8'h32});
         bcode = btxt_ff[0][2:0];
      end else if (blen_ff == 2'd2) begin
         if (btxt_ff[0] == 8'h33 && btxt_ff[1] == 8'h35) begin
            bcode_ok = 1'b1; bcode = 3'd3;
         end else if (btxt_ff[0] == 8'h33 && (btxt_ff[1] == 8'h32 || btxt_ff[1] == 8'h34)) begin
            bcode_ok = 1'b1; bcode = 3'd4;
         end else if (btxt_ff[0] == 8'h36 && btxt_ff[1] == 8'h34) begin
            bcode_ok = 1'b1; bcode = 3'd5;
         end else if (btxt_ff[0] == 8'h36 && btxt_ff[1] == 8'h35) begin
            bcode_ok = 1'b1; bcode = 3'd6;
         end
      end
      bbit = 7'd1 << bcode;

      case (mode_ff)
         M_NORMAL: begin
            if (b == tei_pkg::CH_ESC && more) mode_in = M_ESC;
            else begin
               r0_v = plain_ok(b);
               r0 = plain_item(b);
            end
         end
         M_ESC: begin
            if (b == 8'h5B) begin
               mode_in = M_CSI;
               csi_len_in = 3'd0;
            end else begin
               mode_in = M_NORMAL;
               r0_v = 1'b1;
               r0 = mk(tei_pkg::KIND_KEY, tei_pkg::KEY_ESCAPE, 8'h00);
               r1_v = plain_ok(b);
               r1 = plain_item(b);
            end
         end
         M_CSI: begin
            if (csi_len_ff == 3'd0) begin
               mode_in = M_NORMAL;
               case (b)
                  8'h41: begin r0_v = 1'b1; r0 = mk(tei_pkg::KIND_KEY, tei_pkg::KEY_UP, 8'h00); end
                  8'h42: begin r0_v = 1'b1; r0 = mk(tei_pkg::KIND_KEY, tei_pkg::KEY_DOWN, 8'h00); end
                  8'h43: begin r0_v = 1'b1; r0 = mk(tei_pkg::KIND_KEY, tei_pkg::KEY_RIGHT, 8'h00); end
                  8'h44: begin r0_v = 1'b1; r0 = mk(tei_pkg::KIND_KEY, tei_pkg::KEY_LEFT, 8'h00); end
                  8'h3C: begin
                     mode_in = M_MOUSE;
                     sect_in = 2'd0;
                     blen_in = 2'd0;
                     acc_in[0] = '0; acc_in[1] = '0;
                     flg_in[0] = '0; flg_in[1] = '0;
                  end
                  8'h32: begin
                     mode_in = M_CSI;
                     csi_in[0] = b;
                     csi_len_in = 3'd1;
                  end
                  default: ;
               endcase
            end else if (csi_len_ff >= 3'd4) begin
               csi_len_in = 3'd0;
               mode_in = M_NORMAL;
            end else begin
               csi_in[csi_len_ff[1:0]] = b;
               csi_len_in = csi_len_ff + 3'd1;
               if (csi_len_ff == 3'd1 && b == 8'h7E) begin
                  r0_v = 1'b1;
                  r0 = mk(tei_pkg::KIND_KEY, tei_pkg::KEY_INSERT, 8'h00);
                  csi_len_in = 3'd0;
                  mode_in = M_NORMAL;
               end else if (csi_len_ff == 3'd3 && csi_ff[1] == 8'h30 && csi_ff[2] == 8'h30
                            && b == 8'h7E) begin
                  csi_len_in = 3'd0;
                  fill_in = 3'd0;
                  mode_in = M_PASTE;
               end
            end
         end
         M_MOUSE: begin
            if (b == 8'h4D || b == 8'h6D) begin
               mode_in = M_NORMAL;
               mouse_ok = sect_ff == 2'd2 && bcode_ok && flg_ff[0][1] && !flg_ff[0][3]
                          && flg_ff[1][1] && !flg_ff[1][3];
               if (mouse_ok) begin
                  pmap_in = rel ? (pmap_ff & ~bbit) : (pmap_ff | bbit);
                  rmap_in = rel ? (rmap_ff | bbit) : (rmap_ff & ~bbit);
                  r0_v = 1'b1;
                  r0 = mk(tei_pkg::KIND_MOUSE, 4'd0, 8'h00);
                  r0.mouse_button = bcode;
                  r0.mouse_released = rel;
                  r0.mouse_x = cval[0][15:0];
                  r0.mouse_y = cval[1][15:0];
               end
            end else if (sect_ff == 2'd0) begin
               if (b == 8'h3B) sect_in = 2'd1;
               else if (blen_ff < 2'd2) begin
                  btxt_in[blen_ff[0]] = b;
                  blen_in = blen_ff + 2'd1;
               end else blen_in = 2'd3;
            end else if (sect_ff == 2'd1 && b == 8'h3B) begin
               sect_in = 2'd2;
            end else begin
               for (int k = 0; k < 2; k++) begin
                  if ((k == 0) == (sect_ff == 2'd1) && !flg_ff[k][2]) begin
                     if (is_digit) begin
                        flg_in[k][1] = 1'b1;
                        if (!flg_ff[k][3]) begin
                           if (acc10[k] > (AW + 4)'(COORD_MAX)) flg_in[k][3] = 1'b1;
                           else acc_in[k] = acc10[k][AW-1:0];
                        end
                     end else if (b == 8'h2D && flg_ff[k] == 4'd0) flg_in[k][0] = 1'b1;
                     else flg_in[k][2] = 1'b1;
                  end
               end
            end
         end
         M_PASTE: begin
            if (fill_ff < 3'd5) begin
               win_in[fill_ff] = b;
               fill_in = fill_ff + 3'd1;
            end else if (win_ff[0] == tei_pkg::CH_ESC && win_ff[1] == 8'h5B
                         && win_ff[2] == 8'h32 && win_ff[3] == 8'h30 && win_ff[4] == 8'h31
                         && b == 8'h7E) begin
               r0_v = 1'b1;
               r0 = mk(tei_pkg::KIND_PASTE_END, 4'd0, 8'h00);
               fill_in = 3'd0;
               mode_in = M_NORMAL;
            end else begin
               r0_v = 1'b1;
               r0 = mk(tei_pkg::KIND_PASTE, 4'd0, win_ff[0]);
               for (int i = 0; i < 4; i++) win_in[i] = win_ff[i+1];
               win_in[4] = b;
               fill_in = 3'd5;
            end
         end
         default: mode_in = M_NORMAL;
      endcase

      // maps reflect state after the result; the escape item precedes any change
      r0.pressed_map = pmap_in;
      r0.released_map = rmap_in;
      r1.pressed_map = pmap_in;
      r1.released_map = rmap_in;
      r0.last_of_run = !r1_v;
      r1.last_of_run = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
         hold_vld_ff <= 1'b0;
         mode_ff <= M_NORMAL;
         csi_len_ff <= '0;
         sect_ff <= '0;
         blen_ff <= '0;
         acc_ff[0] <= '0;
         acc_ff[1] <= '0;
         flg_ff[0] <= '0;
         flg_ff[1] <= '0;
         fill_ff <= '0;
         pmap_ff <= '0;
         rmap_ff <= '0;
      end else begin
         if (req_ready) begin
            in_vld_ff <= req_valid;
         end
         if (fire) begin
            mode_ff <= mode_in;
            csi_len_ff <= csi_len_in;
            sect_ff <= sect_in;
            blen_ff <= blen_in;
            acc_ff <= acc_in;
            flg_ff <= flg_in;
            fill_ff <= fill_in;
            pmap_ff <= pmap_in;
            rmap_ff <= rmap_in;
         end
         if (hold_vld_ff) begin
            if (rsp_ready) begin
               out_vld_ff <= 1'b1;
               hold_vld_ff <= 1'b0;
            end
         end else if (fire) begin
            out_vld_ff <= r0_v || r1_v;
            hold_vld_ff <= r0_v && r1_v;
         end else if (rsp_ready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) in_ff <= req_data;
      if (fire) begin
         csi_ff <= csi_in;
         btxt_ff <= btxt_in;
         win_ff <= win_in;
      end
      if (hold_vld_ff) begin
         if (rsp_ready) out_ff <= hold_ff;
      end else if (fire) begin
         out_ff <= r0_v ? r0 : r1;
         hold_ff <= r1;
      end
   end

endmodule

### rtl/tei_checker.sv
// port-level checker for the terminal escape input decoder, with its bind
module tei_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input tei_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.event_kind <= tei_pkg::KIND_PASTE_END)
      else $error("event kind out of range");

   a_maps_disjoint: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.pressed_map & rsp_data.released_map) == 7'd0)
      else $error("button both pressed and released");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result right after reset");

   // with nothing waiting on the result side the input is always open
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      req_valid && !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

endmodule

bind terminal_escape_input_decoder tei_checker u_tei_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
);
